// ----- rtl/core/nthr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Newton n-th root unit.
// No dependencies; imported by the interfaces and the core.
package nthr_pkg;

  localparam int VAL_W  = 32;  // Q-format value width
  localparam int DEG_W  = 5;   // root degree field width
  localparam int STEP_W = 6;   // step count register width

  localparam logic [STEP_W-1:0] STEP_RESET = 6'd10;
  localparam logic [VAL_W-1:0]  VAL_MAX    = {VAL_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SAT,
    ST_DIV,
    ST_DIFF,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/nthr_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the root unit's request and result.
// Depends on nthr_pkg for payload widths.
interface nthr_req_if;
  import nthr_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] radicand;
  logic [DEG_W-1:0] degree;
  modport source (output valid, output radicand, output degree, input ready);
  modport sink   (input valid, input radicand, input degree, output ready);
endinterface

interface nthr_rsp_if;
  import nthr_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] root;
  logic             saturated;
  modport source (output valid, output root, output saturated, input ready);
  modport sink   (input valid, input root, input saturated, output ready);
endinterface

// ----- rtl/core/newton_nth_root_unit.sv -----
`timescale 1ns / 1ps
// Newton n-th root unit: top level, one sequencer around a shared multiplier and divider.
// Depends on nthr_pkg and the channel interfaces in nthr_if.sv.
//
// Computes the degree-th root of an unsigned fixed-point radicand (FRAC_BITS fraction
// bits in 32) by Newton iteration from 1.0, running step_count-1 iterations. One
// request is worked at a time; req.ready is high only while the sequencer is idle,
// and a finished result sits in an output register so the next request can be taken
// while it waits. In each iteration the power x^(n-1) goes through one 32x32
// multiplier (multiply, then saturate), and the quotient and the correction divide
// by n share one radix-2 restoring divider, one quotient bit per cycle. Degree one,
// zero radicand or step_count below two skip the iterations and go straight to the
// done state. saturated reports any clipped product or quotient, or a zero divisor.
module newton_nth_root_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_DEGREE = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [nthr_pkg::STEP_W-1:0] cfg_wr_data,
  nthr_req_if.sink                  req,
  nthr_rsp_if.source                rsp
);
  import nthr_pkg::*;

  localparam int NUMW  = VAL_W + FRAC_BITS;   // dividend width for (q << F) / p
  localparam int CNT_W = $clog2(NUMW + 1);
  localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

  state_t state, state_next;

  logic [STEP_W-1:0]  step_count;
  logic [STEP_W-1:0]  iter;
  logic [VAL_W-1:0]   q;
  logic [DEG_W-1:0]   n;
  logic [DEG_W-1:0]   mul_cnt;
  logic [VAL_W-1:0]   x;
  logic [VAL_W-1:0]   p;
  logic [2*VAL_W-1:0] prod;
  logic [NUMW-1:0]    dq;
  logic [VAL_W-1:0]   rem;
  logic [VAL_W-1:0]   den;
  logic [CNT_W-1:0]   cnt;
  logic [VAL_W-1:0]   d;
  logic               neg;
  logic               flag;
  logic               out_vld;
  logic [VAL_W-1:0]   out_root;
  logic               out_sat;

  logic [DEG_W-1:0]   deg_in;
  logic [VAL_W:0]     rem_sh;
  logic [VAL_W:0]     rem_dif;
  logic               ge;
  logic [2*VAL_W-1:0] prod_sh;
  logic               mul_ovf;
  logic               div_ovf;
  logic [VAL_W-1:0]   mag;
  logic [VAL_W-1:0]   x_new;
  logic               out_free;

  // degree zero acts as one; degrees above the limit are clamped
  always_comb begin
    if (req.degree == '0) begin
      deg_in = DEG_W'(1);
    end else if (int'(req.degree) > MAX_DEGREE) begin
      deg_in = DEG_W'(MAX_DEGREE);
    end else begin
      deg_in = req.degree;
    end
  end

  // shared restoring divider step
  assign rem_sh  = {rem, dq[NUMW-1]};
  assign rem_dif = rem_sh - {1'b0, den};
  assign ge      = !rem_dif[VAL_W];

  assign prod_sh = prod >> FRAC_BITS;
  assign mul_ovf = (prod_sh[2*VAL_W-1:VAL_W] != '0);
  assign div_ovf = (dq[NUMW-1:VAL_W] != '0);

  assign mag   = (d < x) ? (x - d) : (d - x);
  assign x_new = neg ? (x - dq[VAL_W-1:0]) : (x + dq[VAL_W-1:0]);

  assign out_free = !out_vld || rsp.ready;

  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = out_vld;
  assign rsp.root      = out_root;
  assign rsp.saturated = out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (deg_in <= DEG_W'(1) || req.radicand == '0 || step_count <= STEP_W'(1)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        if (mul_cnt != '0) begin
          state_next = ST_MUL;
        end else if (p == '0) begin
          state_next = ST_DIFF;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_MUL:  state_next = ST_SAT;
      ST_SAT:  state_next = ST_PREP;
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_SCALE;
      ST_SCALE: begin
        if (cnt == '0) begin
          state_next = (iter == STEP_W'(1)) ? ST_DONE : ST_PREP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= STEP_RESET;
    end else if (cfg_wr_en) begin
      step_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_root <= x;
      out_sat  <= flag;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q       <= req.radicand;
        n       <= deg_in;
        mul_cnt <= deg_in - DEG_W'(2);
        iter    <= step_count - STEP_W'(1);
        flag    <= 1'b0;
        p       <= ONE;
        if (deg_in <= DEG_W'(1) || req.radicand == '0) begin
          x <= req.radicand;
        end else begin
          x <= ONE;
        end
      end
      ST_PREP: begin
        if (mul_cnt == '0) begin
          if (p == '0) begin
            d    <= VAL_MAX;
            flag <= 1'b1;
          end else begin
            dq  <= {q, {FRAC_BITS{1'b0}}};
            rem <= '0;
            den <= p;
            cnt <= CNT_W'(NUMW);
          end
        end
      end
      ST_MUL: begin
        prod <= (2*VAL_W)'(p) * (2*VAL_W)'(x);
      end
      ST_SAT: begin
        p       <= mul_ovf ? VAL_MAX : prod_sh[VAL_W-1:0];
        flag    <= flag | mul_ovf;
        mul_cnt <= mul_cnt - DEG_W'(1);
      end
      ST_DIV, ST_SCALE: begin
        if (cnt != '0) begin
          rem <= ge ? rem_dif[VAL_W-1:0] : rem_sh[VAL_W-1:0];
          dq  <= {dq[NUMW-2:0], ge};
          cnt <= cnt - CNT_W'(1);
        end else if (state == ST_DIV) begin
          d    <= div_ovf ? VAL_MAX : dq[VAL_W-1:0];
          flag <= flag | div_ovf;
        end else begin
          // signed correction, truncated toward zero
          x       <= x_new;
          p       <= x_new;
          iter    <= iter - STEP_W'(1);
          mul_cnt <= n - DEG_W'(2);
        end
      end
      ST_DIFF: begin
        neg <= (d < x);
        dq  <= {mag, {FRAC_BITS{1'b0}}};
        rem <= '0;
        den <= VAL_W'(n);
        cnt <= CNT_W'(VAL_W);
      end
      default: begin
      end
    endcase
  end

endmodule
